// ===== rtl/fm_two_operator_oscillator_core_macros.svh =====
`ifndef FM_TWO_OPERATOR_OSCILLATOR_CORE_MACROS_SVH
`define FM_TWO_OPERATOR_OSCILLATOR_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define FM2OP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define FM2OP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/fm2op_pkg.sv =====
package fm2op_pkg;

    localparam int SINE_SIZE  = 512;
    localparam int IDX_W      = $clog2(SINE_SIZE + 1);
    localparam int SCALED_W   = 15 + $clog2(SINE_SIZE);
    localparam int PHASE_W    = 31;
    localparam int SAMPLE_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;
    localparam int MUL_A_W    = 17;
    localparam int MUL_B_W    = 16;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int OFFSET_W   = PROD_W - 15;

    localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;

    typedef enum logic [1:0] {
        WAVE_SINE   = 2'd0,
        WAVE_SQUARE = 2'd1,
        WAVE_SAW    = 2'd2,
        WAVE_SILENT = 2'd3
    } wave_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CAR_INC   = 3'd0,
        REG_MOD_INC   = 3'd1,
        REG_CAR_WAVE  = 3'd2,
        REG_MOD_WAVE  = 3'd3,
        REG_MOD_INDEX = 3'd4
    } cfg_idx_t;

    typedef enum logic {
        OP_MOD = 1'b0,
        OP_CAR = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PH,
        S_MA,
        S_MB,
        S_OFS
    } state_t;

    typedef logic signed [SAMPLE_W-1:0] sine_rom_t [0:SINE_SIZE];

    function automatic longint quarter_sine(int unsigned j);
        longint unsigned x;
        longint unsigned term;
        longint          sum;
        int              k;
        x    = TWO_PI_Q30 * longint'(j) / SINE_SIZE;
        term = x;
        sum  = longint'(x);
        for (k = 1; k < 16; k++)
        begin
            term = ((((term * x) >> 30) * x) >> 30);
            case (k)
                1:       term = term / 64'd6;
                2:       term = term / 64'd20;
                3:       term = term / 64'd42;
                4:       term = term / 64'd72;
                5:       term = term / 64'd110;
                6:       term = term / 64'd156;
                7:       term = term / 64'd210;
                8:       term = term / 64'd272;
                9:       term = term / 64'd342;
                10:      term = term / 64'd420;
                11:      term = term / 64'd506;
                12:      term = term / 64'd600;
                13:      term = term / 64'd702;
                14:      term = term / 64'd812;
                default: term = term / 64'd930;
            endcase
            if (k % 2 == 1)
            begin
                sum = sum - longint'(term);
            end
            else
            begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0)
        begin
            sum = 0;
        end
        return (sum + 64'sd16384) >>> 15;
    endfunction

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t   rom;
        int unsigned half;
        int unsigned r;
        int unsigned j;
        longint      v;
        half = SINE_SIZE / 2;
        for (int unsigned i = 0; i <= SINE_SIZE; i++)
        begin
            r = (i <= half) ? i : i - half;
            j = (4 * r <= SINE_SIZE) ? r : half - r;
            v = quarter_sine(j);
            if (i <= half)
            begin
                rom[i] = (v > 32767) ? 16'sd32767 : SAMPLE_W'(v);
            end
            else
            begin
                rom[i] = SAMPLE_W'(-v);
            end
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

// ===== rtl/fm2op_req_if.sv =====
interface fm2op_req_if;
    logic valid;
    logic ready;
    logic block_end;

    modport source (output valid, output block_end, input ready);
    modport sink (input valid, input block_end, output ready);
endinterface

// ===== rtl/fm2op_res_if.sv =====
interface fm2op_res_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [fm2op_pkg::SAMPLE_W-1:0] sample;
    logic                                 last;

    modport source (output valid, output sample, output last, input ready);
    modport sink (input valid, input sample, input last, output ready);
endinterface

// ===== rtl/fm2op_cfg_if.sv =====
interface fm2op_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [fm2op_pkg::CFG_IDX_W-1:0]    index;
    logic [fm2op_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/fm_two_operator_oscillator_core.sv =====
// channel  dir  payload                         accepted when
// req      in   block_end                       req.valid & req.ready
// res      out  sample, last                    res.valid & res.ready
// cfg      in   index, data                     cfg.valid & cfg.ready (ready always high)
//
// A request steps through the accept, then a phase read, two multiply steps
// for the modulator, the offset step, then the carrier's read and two multiply steps.
// The single shared 17x16 multiplier and the registered phase memory read set that sequence.
// Reset clears phase valid bits, so both phases read as zero until first written.
// A result waiting in the output register blocks only the final carrier step.
`include "fm_two_operator_oscillator_core_macros.svh"

module fm_two_operator_oscillator_core
(
    input  logic        clk,
    input  logic        rst_n,
    fm2op_req_if.sink   req,
    fm2op_res_if.source res,
    fm2op_cfg_if.sink   cfg
);
    import fm2op_pkg::*;

    state_t                        state_reg;
    state_t                        state_next;
    op_t                           op_reg;
    op_t                           op_next;

    logic [PHASE_W-1:0]            car_inc_reg;
    logic [PHASE_W-1:0]            mod_inc_reg;
    wave_t                         car_wave_reg;
    wave_t                         mod_wave_reg;
    logic signed [SAMPLE_W-1:0]    mod_index_reg;

    logic [PHASE_W-1:0]            phase_mem [2];
    logic [1:0]                    phase_vld_reg;
    logic [PHASE_W-1:0]            phase_rd_reg;
    logic                          phase_rd_vld_reg;
    op_t                           phase_rd_addr;
    logic                          phase_we;
    logic [PHASE_W-1:0]            phase_cur;
    logic [PHASE_W-1:0]            phase_new;

    logic [SCALED_W-1:0]           scaled;
    logic [IDX_W-1:0]              idx_a;
    logic [IDX_W-1:0]              idx_b;

    logic [PHASE_W-1:0]            phase_reg;
    logic [14:0]                   frac_reg;
    logic signed [SAMPLE_W-1:0]    a_reg;
    logic signed [SAMPLE_W-1:0]    b_reg;
    logic signed [SAMPLE_W-1:0]    t_reg;
    logic signed [SAMPLE_W-1:0]    mod_sample_reg;
    logic [PHASE_W-1:0]            step_reg;
    logic                          last_reg;

    logic signed [MUL_A_W-1:0]     mul_a;
    logic signed [MUL_B_W-1:0]     mul_b;
    logic signed [PROD_W-1:0]      prod;
    logic signed [OFFSET_W-1:0]    offset;
    logic [SAMPLE_W-1:0]           u_sum;
    logic signed [SAMPLE_W-1:0]    wave_out;
    wave_t                         wave_sel;

    logic                          out_valid_reg;
    logic signed [SAMPLE_W-1:0]    out_sample_reg;
    logic                          out_last_reg;
    logic                          out_free;
    logic                          out_load;
    logic                          req_fire;

    assign req.ready  = (state_reg == S_IDLE);
    assign req_fire   = req.valid && req.ready;
    assign cfg.ready  = 1'b1;
    assign res.valid  = out_valid_reg;
    assign res.sample = out_sample_reg;
    assign res.last   = out_last_reg;
    assign out_free   = !out_valid_reg || res.ready;

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        out_load      = 1'b0;
        phase_we      = 1'b0;
        phase_rd_addr = OP_MOD;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = S_PH;
                    op_next    = OP_MOD;
                end
            end
            S_PH:
            begin
                phase_we   = 1'b1;
                state_next = S_MA;
            end
            S_MA:
            begin
                state_next = S_MB;
            end
            S_MB:
            begin
                if (op_reg == OP_MOD)
                begin
                    state_next = S_OFS;
                end
                else if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_OFS:
            begin
                phase_rd_addr = OP_CAR;
                state_next    = S_PH;
                op_next       = OP_CAR;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_MOD;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            car_inc_reg   <= '0;
            mod_inc_reg   <= '0;
            car_wave_reg  <= WAVE_SILENT;
            mod_wave_reg  <= WAVE_SILENT;
            mod_index_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_CAR_INC:   car_inc_reg   <= cfg.data;
                REG_MOD_INC:   mod_inc_reg   <= cfg.data;
                REG_CAR_WAVE:  car_wave_reg  <= wave_t'(cfg.data[1:0]);
                REG_MOD_WAVE:  mod_wave_reg  <= wave_t'(cfg.data[1:0]);
                REG_MOD_INDEX: mod_index_reg <= cfg.data[SAMPLE_W-1:0];
                default:       ;
            endcase
        end
    end

    // phase memory
    assign phase_cur = phase_rd_vld_reg ? phase_rd_reg : '0;
    assign phase_new = phase_cur + ((op_reg == OP_CAR) ? step_reg : mod_inc_reg);

    always_ff @(posedge clk)
    begin
        if (phase_we)
        begin
            phase_mem[op_reg] <= phase_new;
        end
        phase_rd_reg <= phase_mem[phase_rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_vld_reg    <= '0;
            phase_rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (phase_we)
            begin
                phase_vld_reg[op_reg] <= 1'b1;
            end
            phase_rd_vld_reg <= phase_vld_reg[phase_rd_addr];
        end
    end

    // table index and fraction
    assign scaled = SCALED_W'(phase_cur[PHASE_W-1:16]) * SCALED_W'(SINE_SIZE);
    assign idx_a  = IDX_W'(scaled >> 15);
    assign idx_b  = idx_a + 1'b1;

    // shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_MA:
            begin
                mul_a = MUL_A_W'(17'sd32768 - MUL_A_W'({2'b00, frac_reg}));
                mul_b = a_reg;
            end
            S_MB:
            begin
                mul_a = MUL_A_W'({2'b00, frac_reg});
                mul_b = b_reg;
            end
            S_OFS:
            begin
                mul_a = MUL_A_W'(mod_sample_reg);
                mul_b = mod_index_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod   = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign offset = prod[PROD_W-1:15];
    assign u_sum  = t_reg + prod[31:16];

    assign wave_sel = (op_reg == OP_CAR) ? car_wave_reg : mod_wave_reg;

    always_comb
    begin
        case (wave_sel)
            WAVE_SINE:   wave_out = {u_sum[SAMPLE_W-2:0], 1'b0};
            WAVE_SQUARE: wave_out = phase_reg[PHASE_W-1] ? -16'sd32768 : 16'sd32767;
            WAVE_SAW:    wave_out = {1'b0, phase_reg[PHASE_W-1:16]};
            default:     wave_out = '0;
        endcase
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            last_reg <= req.block_end;
        end
        if (state_reg == S_PH)
        begin
            phase_reg <= phase_cur;
            frac_reg  <= scaled[14:0];
            a_reg     <= SINE_ROM[idx_a];
            b_reg     <= SINE_ROM[idx_b];
        end
        if (state_reg == S_MA)
        begin
            t_reg <= prod[31:16];
        end
        if (state_reg == S_MB && op_reg == OP_MOD)
        begin
            mod_sample_reg <= wave_out;
        end
        if (state_reg == S_OFS)
        begin
            step_reg <= car_inc_reg + PHASE_W'(offset);
        end
        if (out_load)
        begin
            out_sample_reg <= wave_out;
            out_last_reg   <= last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    `FM2OP_ASSERT_NEXT(a_accept_starts_mod, req_fire,
        state_reg == S_PH && op_reg == OP_MOD, "request did not start modulator read")
    `FM2OP_ASSERT_NEXT(a_ofs_starts_car, state_reg == S_OFS,
        state_reg == S_PH && op_reg == OP_CAR, "offset step did not start carrier read")
    `FM2OP_ASSERT_NEXT(a_car_done_out, state_reg == S_MB && op_reg == OP_CAR && out_free,
        out_valid_reg && state_reg == S_IDLE, "carrier result not delivered")
    `FM2OP_ASSERT_NOW(a_out_from_car, $rose(out_valid_reg),
        $past(state_reg) == S_MB && $past(op_reg) == OP_CAR, "result raised outside carrier step")

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

import fm2op_pkg::*;

typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
} voice_out_t;

class fm_voice_board;
    localparam longint unsigned TURN_Q30 = 64'd6746518852;

    bit [PHASE_W-1:0]         car_inc;
    bit [PHASE_W-1:0]         mod_inc;
    wave_t                    car_wave;
    wave_t                    mod_wave;
    bit signed [SAMPLE_W-1:0] mod_idx;
    bit [PHASE_W-1:0]         car_phase;
    bit [PHASE_W-1:0]         mod_phase;
    int                       sine_pts [SINE_SIZE+1];
    voice_out_t               expected_samples [$];
    int                       mismatches;
    int                       checked;
    int                       writes;

    function new();
        int unsigned half;
        int unsigned r;
        int unsigned j;
        longint      v;
        half = SINE_SIZE / 2;
        for (int unsigned i = 0; i <= SINE_SIZE; i++)
        begin
            r = (i <= half) ? i : i - half;
            j = (4 * r <= SINE_SIZE) ? r : half - r;
            v = sine_quarter_point(j);
            if (i <= half)
                sine_pts[i] = (v > 32767) ? 32767 : int'(v);
            else
                sine_pts[i] = -int'(v);
        end
        car_inc    = '0;
        mod_inc    = '0;
        car_wave   = WAVE_SILENT;
        mod_wave   = WAVE_SILENT;
        mod_idx    = '0;
        car_phase  = '0;
        mod_phase  = '0;
        mismatches = 0;
        checked    = 0;
        writes     = 0;
    endfunction

    // round(32768 * sin(2*pi*j/SIZE)) by Taylor series in Q30
    function longint sine_quarter_point(int unsigned j);
        longint unsigned x;
        longint unsigned term;
        longint          acc;
        longint unsigned k;
        x    = TURN_Q30 * longint'(j) / SINE_SIZE;
        term = x;
        acc  = longint'(x);
        for (k = 1; k < 16 && term != 0; k++)
        begin
            term = (((term * x) >> 30) * x) >> 30;
            term = term / ((2 * k) * (2 * k + 1));
            if (k[0])
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        if (acc < 0)
            acc = 0;
        return (acc + 16384) >>> 15;
    endfunction

    function longint to_q15(longint v);
        logic signed [15:0] s;
        s = v[15:0];
        return s;
    endfunction

    function int wave_value(wave_t w, bit [PHASE_W-1:0] p);
        int unsigned x;
        int unsigned scaled;
        int unsigned idx;
        longint      f;
        longint      a;
        longint      b;
        longint      t;
        longint      u;
        x = 32'(p[30:16]);
        case (w)
            WAVE_SINE:
            begin
                scaled = x * SINE_SIZE;
                idx    = (scaled >> 15) % SINE_SIZE;
                f      = scaled & 32'h7FFF;
                a      = sine_pts[idx];
                b      = sine_pts[idx+1];
                t      = to_q15(((32768 - f) * a) >>> 16);
                u      = to_q15((t * 65536 + f * b) >>> 16);
                return int'(to_q15(u * 2));
            end
            WAVE_SQUARE: return (p < 31'h40000000) ? 32767 : -32768;
            WAVE_SAW:    return int'(x);
            default:     return 0;
        endcase
    endfunction

    function void write_reg(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] data);
        writes++;
        case (idx)
            REG_CAR_INC:   car_inc  = data[PHASE_W-1:0];
            REG_MOD_INC:   mod_inc  = data[PHASE_W-1:0];
            REG_CAR_WAVE:  car_wave = wave_t'(data[1:0]);
            REG_MOD_WAVE:  mod_wave = wave_t'(data[1:0]);
            REG_MOD_INDEX: mod_idx  = data[15:0];
            default: ;
        endcase
    endfunction

    function void note_request(bit block_end);
        int         ms;
        int         cs;
        longint     offset;
        longint     next_phase;
        voice_out_t exp_out;
        ms        = wave_value(mod_wave, mod_phase);
        mod_phase = mod_phase + mod_inc;
        offset    = (longint'(ms) * longint'(mod_idx)) >>> 15;
        cs        = wave_value(car_wave, car_phase);
        next_phase = longint'(car_phase) + longint'(car_inc) + offset;
        car_phase = next_phase[PHASE_W-1:0];
        exp_out.sample = cs[15:0];
        exp_out.last   = block_end;
        expected_samples.push_back(exp_out);
    endfunction

    function void check_sample(logic signed [SAMPLE_W-1:0] sample, logic last);
        voice_out_t exp_out;
        if (expected_samples.size() == 0)
        begin
            $error("sample %0d arrived with no request outstanding", sample);
            mismatches++;
            return;
        end
        exp_out = expected_samples.pop_front();
        checked++;
        if (sample !== exp_out.sample)
        begin
            $error("sample: expected %0d, actual %0d", exp_out.sample, sample);
            mismatches++;
        end
        if (last !== exp_out.last)
        begin
            $error("last: expected %0b, actual %0b", exp_out.last, last);
            mismatches++;
        end
    endfunction

    function int pending();
        return expected_samples.size();
    endfunction
endclass

module tb_top;
    logic clk;
    logic rst_n;
    int   gap_pct;
    int   sent;
    int   settings;

    fm_voice_board board = new();

    fm2op_req_if req_ch ();
    fm2op_res_if res_ch ();
    fm2op_cfg_if cfg_ch ();

    fm_two_operator_oscillator_core dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    initial
    begin
        #5ms;
        $display("Verification failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
            board.check_sample(res_ch.sample, res_ch.last);
        res_ch.ready <= ($urandom_range(0, 99) >= gap_pct);
    end

    task automatic send_request(input bit block_end);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.block_end <= block_end;
        do
            @(posedge clk);
        while (!req_ch.ready);
        board.note_request(block_end);
        sent++;
    endtask

    task automatic send_burst(input int n);
        for (int i = 0; i < n; i++)
            send_request(1'($urandom_range(0, 1)));
    endtask

    // drop the request and hold until the pipeline has drained
    task automatic settle();
        req_ch.valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        board.write_reg(idx, data);
    endtask

    task automatic program_voice(input bit [PHASE_W-1:0] ci, input bit [PHASE_W-1:0] mi,
                                 input wave_t cw, input wave_t mw, input bit [15:0] mx);
        logic [CFG_DATA_W-1:0] d;
        write_register(REG_CAR_INC, ci);
        write_register(REG_MOD_INC, mi);
        d = CFG_DATA_W'($urandom);
        d[1:0] = cw;
        write_register(REG_CAR_WAVE, d);
        d = CFG_DATA_W'($urandom);
        d[1:0] = mw;
        write_register(REG_MOD_WAVE, d);
        d = CFG_DATA_W'($urandom);
        d[15:0] = mx;
        write_register(REG_MOD_INDEX, d);
        cfg_ch.valid <= 1'b0;
        settings++;
    endtask

    function automatic bit [PHASE_W-1:0] pick_increment();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return 31'h7FFFFFFF;
            2:       return PHASE_W'($urandom_range(0, 1 << 20));
            3:       return PHASE_W'($urandom_range(0, 1 << 26));
            default: return PHASE_W'($urandom);
        endcase
    endfunction

    function automatic bit [15:0] pick_index();
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic shuffle_voice();
        logic [CFG_DATA_W-1:0] d;
        if ($urandom_range(0, 3) != 0)
            write_register(REG_CAR_INC, pick_increment());
        if ($urandom_range(0, 3) != 0)
            write_register(REG_MOD_INC, pick_increment());
        if ($urandom_range(0, 2) != 0)
            write_register(REG_CAR_WAVE, CFG_DATA_W'($urandom));
        if ($urandom_range(0, 2) != 0)
            write_register(REG_MOD_WAVE, CFG_DATA_W'($urandom));
        if ($urandom_range(0, 2) != 0)
        begin
            d = CFG_DATA_W'($urandom);
            d[15:0] = pick_index();
            write_register(REG_MOD_INDEX, d);
        end
        if ($urandom_range(0, 5) == 0)
            write_register(CFG_IDX_W'($urandom_range(int'(REG_MOD_INDEX) + 1,
                                                     (1 << CFG_IDX_W) - 1)),
                           CFG_DATA_W'($urandom));
        cfg_ch.valid <= 1'b0;
        settings++;
    endtask

    initial
    begin
        int target;
        int phase;
        rst_n            = 1'b0;
        gap_pct          = 31;
        sent             = 0;
        settings         = 0;
        req_ch.valid     = 1'b0;
        req_ch.block_end = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = '0;
        cfg_ch.data      = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(1'b0);
        send_request(1'b1);
        settle();

        program_voice(31'h7FFFFFFF, '0, WAVE_SINE, WAVE_SILENT, 16'h0000);
        send_burst(3);
        settle();

        // negative modulated step
        program_voice('0, 31'h40000000, WAVE_SQUARE, WAVE_SINE, 16'h8000);
        send_burst(4);
        settle();

        // step past the top of the phase range
        program_voice(31'h7FFFFFFF, '0, WAVE_SAW, WAVE_SQUARE, 16'h7FFF);
        send_burst(3);
        settle();

        program_voice('0, 31'h12345678, WAVE_SINE, WAVE_SAW, 16'h8000);
        send_burst(4);
        settle();

        write_register(CFG_IDX_W'(int'(REG_MOD_INDEX) + 1), 31'h7FFFFFFF);
        write_register(CFG_IDX_W'((1 << CFG_IDX_W) - 1), 31'h55555555);
        cfg_ch.valid <= 1'b0;
        send_burst(2);
        settle();

        target = sent + 1500;
        phase  = 0;
        while (sent < target)
        begin
            gap_pct = (phase >= 10 && phase < 15) ? 0 : 31;
            shuffle_voice();
            send_burst($urandom_range(20, 90));
            settle();
            phase++;
        end

        $display("Checked %0d samples over %0d register settings (%0d writes).",
                 board.checked, settings, board.writes);
        $display("Covered all four carrier and modulator waves and index extremes.");
        if (board.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
